>>> rtl/csb_pkg.sv
// Shared types, constants and register map of the carrier-sense backoff sender
package csb_pkg;

    localparam int TIMER_WIDTH_DEF = 24;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SLOT_TIME    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAP_EXPONENT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RANDOM_SEED  = 3'd4;

    localparam logic [7:0]  SLOT_TIME_RST    = 8'd39;
    localparam logic [4:0]  MAX_ATTEMPTS_RST = 5'd16;
    localparam logic [3:0]  CAP_EXPONENT_RST = 4'd10;
    localparam logic [11:0] MAX_LENGTH_RST   = 12'd2312;
    localparam logic [15:0] RANDOM_SEED_RST  = 16'd44257;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    localparam int SLOT_W = 15;
    localparam int PROD_W = 8 + SLOT_W;

    typedef struct packed {
        logic        cmd;
        logic [11:0] payload_len;
        logic        carrier_busy;
    } req_item_t;

    typedef struct packed {
        logic       transmit;
        logic       dropped;
        logic       rejected;
        logic       waiting;
        logic [4:0] attempt_count;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0]  slot_time;
        logic [4:0]  max_attempts;
        logic [3:0]  cap_exponent;
        logic [11:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } seed_load_t;

endpackage

>>> rtl/csb_regs.sv
// APB configuration registers of the carrier-sense backoff sender
module csb_regs
    import csb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg,
    output seed_load_t        seed_load
);

    logic [7:0]           slot_time_reg;
    logic [4:0]           max_attempts_reg;
    logic [3:0]           cap_exponent_reg;
    logic [11:0]          max_length_reg;
    logic [15:0]          random_seed_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_time_reg    <= SLOT_TIME_RST;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            cap_exponent_reg <= CAP_EXPONENT_RST;
            max_length_reg   <= MAX_LENGTH_RST;
            random_seed_reg  <= RANDOM_SEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SLOT_TIME:    slot_time_reg    <= pwdata[7:0];
                REG_MAX_ATTEMPTS: max_attempts_reg <= pwdata[4:0];
                REG_CAP_EXPONENT: cap_exponent_reg <= pwdata[3:0];
                REG_MAX_LENGTH:   max_length_reg   <= pwdata[11:0];
                REG_RANDOM_SEED:  random_seed_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SLOT_TIME:    prdata = DATA_W'(slot_time_reg);
            REG_MAX_ATTEMPTS: prdata = DATA_W'(max_attempts_reg);
            REG_CAP_EXPONENT: prdata = DATA_W'(cap_exponent_reg);
            REG_MAX_LENGTH:   prdata = DATA_W'(max_length_reg);
            REG_RANDOM_SEED:  prdata = DATA_W'(random_seed_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.slot_time    = slot_time_reg;
    assign cfg.max_attempts = max_attempts_reg;
    assign cfg.cap_exponent = cap_exponent_reg;
    assign cfg.max_length   = max_length_reg;

    assign seed_load.load  = wr_en && (idx == REG_RANDOM_SEED);
    assign seed_load.value = pwdata[15:0];

endmodule

>>> rtl/csb_core.sv
// Sender state and per-item backoff decision of the carrier-sense backoff sender
module csb_core
    import csb_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  req_item_t  item,
    input  cfg_t       cfg,
    input  seed_load_t seed_load,
    output rsp_item_t  result
);

    localparam int EXT_W = (TIMER_WIDTH > PROD_W) ? TIMER_WIDTH : PROD_W;

    logic                   wait_flag_reg;
    logic                   wait_flag_next;
    logic [4:0]             attempts_reg;
    logic [4:0]             attempts_next;
    logic [TIMER_WIDTH-1:0] remaining_reg;
    logic [TIMER_WIDTH-1:0] remaining_next;
    logic [15:0]            lfsr_reg;
    logic [15:0]            lfsr_next;

    logic                   feedback;
    logic                   bad_req;
    logic                   do_attempt;
    logic [TIMER_WIDTH-1:0] rem_dec;
    logic [5:0]             count;
    logic [4:0]             expo;
    logic [SLOT_W-1:0]      mask;
    logic [SLOT_W-1:0]      slots;
    logic [PROD_W-1:0]      product;
    logic [EXT_W-1:0]       delay_ext;
    logic [TIMER_WIDTH-1:0] delay;

    assign feedback  = lfsr_reg[15] ^ lfsr_reg[13] ^ lfsr_reg[12] ^ lfsr_reg[10];
    assign lfsr_next = {lfsr_reg[14:0], feedback};

    assign bad_req = wait_flag_reg || (item.payload_len == 12'd0)
                     || (item.payload_len > cfg.max_length);
    assign rem_dec = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;

    assign count   = {1'b0, attempts_reg} + 6'd1;
    assign expo    = (count[4:0] < {1'b0, cfg.cap_exponent}) ? count[4:0]
                     : {1'b0, cfg.cap_exponent};
    assign mask    = SLOT_W'((32'd1 << expo) - 32'd1);
    assign slots   = lfsr_next[SLOT_W-1:0] & mask;
    assign product = PROD_W'(cfg.slot_time * slots);

    assign delay_ext = EXT_W'(product);
    assign delay     = (delay_ext > EXT_W'({TIMER_WIDTH{1'b1}})) ? '1
                       : delay_ext[TIMER_WIDTH-1:0];

    always_comb
    begin
        wait_flag_next  = wait_flag_reg;
        attempts_next   = attempts_reg;
        remaining_next  = remaining_reg;
        result          = '0;
        do_attempt      = 1'b0;

        if (item.cmd == CMD_SEND)
        begin
            if (bad_req)
                result.rejected = 1'b1;
            else
                do_attempt = 1'b1;
        end
        else if (wait_flag_reg)
        begin
            remaining_next = rem_dec;
            if (rem_dec == '0)
            begin
                wait_flag_next = 1'b0;
                do_attempt     = 1'b1;
            end
        end

        if (do_attempt)
        begin
            if (!item.carrier_busy)
            begin
                attempts_next   = '0;
                wait_flag_next  = 1'b0;
                result.transmit = 1'b1;
            end
            else if (count > {1'b0, cfg.max_attempts})
            begin
                attempts_next  = '0;
                wait_flag_next = 1'b0;
                result.dropped = 1'b1;
            end
            else
            begin
                attempts_next  = count[4:0];
                remaining_next = delay;
                wait_flag_next = 1'b1;
            end
        end

        result.waiting       = wait_flag_next;
        result.attempt_count = attempts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_flag_reg <= 1'b0;
            attempts_reg  <= '0;
            remaining_reg <= '0;
            lfsr_reg      <= RANDOM_SEED_RST;
        end
        else if (seed_load.load)
        begin
            lfsr_reg <= (seed_load.value == 16'd0) ? 16'd1 : seed_load.value;
        end
        else if (fire)
        begin
            wait_flag_reg <= wait_flag_next;
            attempts_reg  <= attempts_next;
            remaining_reg <= remaining_next;
            lfsr_reg      <= lfsr_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_wait_has_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        wait_flag_reg |-> (attempts_reg != 5'd0))
        else $error("waiting with no attempt counted");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> $onehot0({result.transmit, result.dropped, result.rejected}))
        else $error("more than one outcome for an item");

    a_sent_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (result.transmit || result.dropped))
        |=> (!wait_flag_reg && (attempts_reg == 5'd0)))
        else $error("state not cleared after transmit or drop");

    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 16'd0)
        else $error("random generator locked at zero");
`endif

endmodule

>>> rtl/carrier_sense_backoff.sv
// Top level of the carrier-sense backoff sender: handshake stages around the core
// An accepted item passes the input register, then the result register,
// before its result is offered.
// Throughput: one item per cycle while the result stage is not stalled by rsp_ready.
// Reset: clears both stages, the sender state and the registers to their defaults,
// and loads the random generator with the default seed.
module carrier_sense_backoff
    import csb_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_item_t         req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_item_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic       stage_valid_reg;
    req_item_t  stage_reg;
    logic       rsp_valid_reg;
    rsp_item_t  rsp_reg;
    logic       advance;
    logic       fire;
    cfg_t       cfg;
    seed_load_t seed_load;
    rsp_item_t  result;

    csb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .seed_load (seed_load)
    );

    csb_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (stage_reg),
        .cfg       (cfg),
        .seed_load (seed_load),
        .result    (result)
    );

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign fire      = stage_valid_reg && advance;
    assign req_ready = !stage_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_ready)
                stage_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            stage_reg <= req;
        if (fire)
            rsp_reg <= result;
    end

`ifndef NO_ASSERTIONS
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("stalled item lost from input stage");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("processed item gave no result");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready && stage_valid_reg) |-> !req_ready)
        else $error("item accepted with both stages full");
`endif

endmodule
